### src/ctrh_pkg.sv
// ----------------------------------------------------------------------------
// CTAPHID response reassembler package
// Word types and protocol constants shared by the reassembler modules.
// ----------------------------------------------------------------------------
package ctrh_pkg;

    localparam logic       C_KIND_ARM        = 1'b0;
    localparam logic       C_KIND_BYTE       = 1'b1;

    localparam logic [6:0] C_CMD_KEEPALIVE   = 7'h3B;
    localparam logic [6:0] C_CMD_ERROR       = 7'h3F;
    localparam logic [7:0] C_ERR_INVALID_SEQ = 8'h04;
    localparam logic [7:0] C_SEQ_EXPECT_INIT = 8'hFF;
    localparam logic [7:0] C_MAX_SEQUENCE    = 8'd128;
    localparam logic [15:0] C_COUNT_MAX      = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [31:0] channel;
        logic [7:0]  data_byte;
        logic        report_end;
    } t_in_word;

    typedef struct packed {
        logic [6:0]  command;
        logic [15:0] message_length;
        logic [7:0]  payload_byte;
        logic        message_done;
        logic        seq_fault;
    } t_out_word;

    typedef struct packed {
        logic      has_result;
        t_out_word result;
    } t_step;

endpackage

### src/ctaphid_response_reassembler.sv
// ----------------------------------------------------------------------------
// CTAPHID response reassembler
// Rebuilds a CTAPHID response from report bytes, one word per cycle unstalled.
// ----------------------------------------------------------------------------
// The input channel carries arm words, which name the channel of the request
// just sent, and report bytes with an end-of-report flag. The output channel
// carries one word per payload byte, plus a done word or an error word.
// An accepted word is held in the input register and handled once the result
// register is free or being emptied; its result is then registered in the
// result register and shown on the output. Throughput is one word per
// cycle while the receiver does not stall, set by the single pass through
// the reassembly core. Words that give no result simply leave no output.
// When the receiver stalls, the result register holds its word and the
// input register fills, after which the input is stalled as well.
// Reset clears both registers and all reassembly state: the block is
// unarmed and expects an initialisation packet.
// ----------------------------------------------------------------------------
module ctaphid_response_reassembler #(
    parameter int REPORT_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ctrh_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ctrh_pkg::t_out_word o_out_word
);
    import ctrh_pkg::*;

    logic     r_in_valid;
    t_in_word r_in_word;
    logic     advance;
    logic     accept;
    t_step    step;

    assign advance    = r_in_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_word <= i_in_word;
        end
    end

    ctrh_core #(
        .REPORT_BYTES(REPORT_BYTES)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (advance),
        .i_word (r_in_word),
        .o_step (step)
    );

    ctrh_out_buf u_out_buf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (advance),
        .i_step (step),
        .i_stall(i_out_stall),
        .o_valid(o_out_valid),
        .o_word (o_out_word)
    );

endmodule

### src/ctrh_core.sv
// ----------------------------------------------------------------------------
// CTAPHID reassembly core
// Holds the running report and message state and handles one word per enabled cycle.
// ----------------------------------------------------------------------------
module ctrh_core #(
    parameter int REPORT_BYTES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  ctrh_pkg::t_in_word i_word,
    output ctrh_pkg::t_step   o_step
);
    import ctrh_pkg::*;

    localparam int PW = $clog2(REPORT_BYTES + 1);
    localparam logic [PW-1:0] P_POS_CMD  = PW'(4);
    localparam logic [PW-1:0] P_POS_LENH = PW'(5);
    localparam logic [PW-1:0] P_POS_DATA = PW'(7);
    localparam logic [PW-1:0] P_POS_LIM  = PW'(REPORT_BYTES);

    logic          r_armed, n_armed;
    logic [31:0]   r_chan, n_chan;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_seq, n_seq;
    logic [6:0]    r_cmd, n_cmd;
    logic [15:0]   r_len, n_len;
    logic [15:0]   r_cnt, n_cnt;
    logic          r_skip, n_skip;

    logic [7:0]    want;
    logic [15:0]   cnt_inc;
    logic          skip_eff;
    logic          fault;
    logic          done;
    logic [7:0]    b;

    always_comb begin
        case (r_pos[1:0])
            2'd0:    want = r_chan[31:24];
            2'd1:    want = r_chan[23:16];
            2'd2:    want = r_chan[15:8];
            default: want = r_chan[7:0];
        endcase
    end

    assign b       = i_word.data_byte;
    assign cnt_inc = (r_cnt != C_COUNT_MAX) ? r_cnt + 16'd1 : r_cnt;

    always_comb begin
        n_armed  = r_armed;
        n_chan   = r_chan;
        n_pos    = r_pos;
        n_seq    = r_seq;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_skip   = r_skip;
        skip_eff = r_skip || !r_armed;
        fault    = 1'b0;
        done     = 1'b0;
        o_step   = '0;

        if (i_word.kind == C_KIND_ARM) begin
            n_armed = 1'b1;
            n_chan  = i_word.channel;
            n_seq   = C_SEQ_EXPECT_INIT;
            n_cmd   = '0;
            n_len   = '0;
            n_cnt   = '0;
            if (r_pos != '0) begin
                n_skip = 1'b1;
            end
        end else begin
            n_skip = skip_eff;
            if (skip_eff) begin
                n_skip = 1'b1;
            end else if (r_pos < P_POS_CMD) begin
                if (b != want) begin
                    n_skip = 1'b1;
                end
            end else if (r_pos == P_POS_CMD) begin
                if (b[7]) begin
                    if (r_seq != C_SEQ_EXPECT_INIT && r_cmd != C_CMD_KEEPALIVE) begin
                        fault = 1'b1;
                    end else begin
                        n_cmd = b[6:0];
                        n_seq = '0;
                        n_cnt = '0;
                        n_len = '0;
                    end
                end else if (b == r_seq && r_seq < C_MAX_SEQUENCE) begin
                    n_seq = r_seq + 8'd1;
                end else begin
                    fault = 1'b1;
                end
            end else if (r_pos < P_POS_DATA && r_seq == '0) begin
                if (r_pos == P_POS_LENH) begin
                    n_len = {b, r_len[7:0]};
                end else begin
                    n_len = {r_len[15:8], b};
                end
            end else if (r_pos < P_POS_LIM) begin
                n_cnt = cnt_inc;
                done  = i_word.report_end && (cnt_inc >= r_len);
                o_step.has_result           = 1'b1;
                o_step.result.command       = r_cmd;
                o_step.result.message_length = r_len;
                o_step.result.payload_byte  = b;
                o_step.result.message_done  = done;
            end else if (i_word.report_end && r_cnt >= r_len) begin
                done = 1'b1;
                o_step.has_result           = 1'b1;
                o_step.result.command       = r_cmd;
                o_step.result.message_length = r_len;
                o_step.result.message_done  = 1'b1;
            end

            if (fault) begin
                n_cmd   = C_CMD_ERROR;
                n_len   = 16'd1;
                n_cnt   = 16'd1;
                n_armed = 1'b0;
                n_skip  = 1'b1;
                o_step.has_result            = 1'b1;
                o_step.result.command        = C_CMD_ERROR;
                o_step.result.message_length = 16'd1;
                o_step.result.payload_byte   = C_ERR_INVALID_SEQ;
                o_step.result.message_done   = 1'b1;
                o_step.result.seq_fault      = 1'b1;
            end else if (done && r_cmd != C_CMD_KEEPALIVE) begin
                n_armed = 1'b0;
            end

            if (i_word.report_end) begin
                n_pos  = '0;
                n_skip = 1'b0;
            end else if (r_pos < P_POS_LIM) begin
                n_pos = r_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_chan  <= '0;
            r_pos   <= '0;
            r_seq   <= C_SEQ_EXPECT_INIT;
            r_cmd   <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_skip  <= 1'b0;
        end else if (i_en) begin
            r_armed <= n_armed;
            r_chan  <= n_chan;
            r_pos   <= n_pos;
            r_seq   <= n_seq;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_skip  <= n_skip;
        end
    end

endmodule

### src/ctrh_out_buf.sv
// ----------------------------------------------------------------------------
// CTAPHID result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module ctrh_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ctrh_pkg::t_step    i_step,
    input  logic               i_stall,
    output logic               o_valid,
    output ctrh_pkg::t_out_word o_word
);
    import ctrh_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_step.has_result;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_step.has_result) begin
            r_word <= i_step.result;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

### src/ctrh_checker.sv
// ----------------------------------------------------------------------------
// CTAPHID response reassembler checker
// Port-level assertions on the reassembler, attached by a bind statement.
// ----------------------------------------------------------------------------
module ctrh_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input ctrh_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ctrh_pkg::t_out_word o_out_word
);
    import ctrh_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_out_valid) && $past(i_out_stall)) |-> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_out_valid) && $past(i_out_stall)) |->
        $stable(o_out_word))
        else $error("stalled output word changed");

    a_fault_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.seq_fault) |->
        (o_out_word.message_done && o_out_word.command == C_CMD_ERROR &&
         o_out_word.message_length == 16'd1 &&
         o_out_word.payload_byte == C_ERR_INVALID_SEQ))
        else $error("malformed sequence fault word");

    a_no_needless_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled while the output is free");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output word valid after reset");

endmodule

bind ctaphid_response_reassembler ctrh_checker u_ctrh_checker (.*);

### tb/tb_ctaphid_response_reassembler.sv
// ----------------------------------------------------------------------------
// CTAPHID response reassembler testbench
// Sends arm words and report bytes through the input channel and checks every
// output word against a cycle-free model of the reassembly rules. Directed
// tests cover channel filtering, length and report-shape corner cases and
// the sequence faults. Random exchanges follow, run under three idling
// patterns, with one long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb_ctaphid_response_reassembler;

    import ctrh_pkg::*;

    localparam int REPORT_BYTES = 64;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 90;

    logic      i_clk    = 1'b0;
    logic      i_rst_n  = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word  = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int mismatch_count = 0;
    int quiet_cycles  = 0;

    t_out_word expected_words[$];

    logic        armed;
    logic [31:0] expected_channel;
    logic [6:0]  byte_pos;
    logic [7:0]  next_seq;
    logic [6:0]  cur_command;
    logic [15:0] declared_len;
    logic [15:0] received_count;
    logic        skip_report;

    ctaphid_response_reassembler #(
        .REPORT_BYTES(REPORT_BYTES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_word (o_out_word)
    );

    always #1 i_clk = ~i_clk;

    task automatic reassemble(input t_in_word w);
        t_out_word r;
        logic      emit;
        logic      fault;
        logic      done;
        int        pos;
        logic [7:0] b;
        emit  = 1'b0;
        fault = 1'b0;
        done  = 1'b0;
        pos   = int'(byte_pos);
        b     = w.data_byte;
        r     = '0;
        if (w.kind == C_KIND_ARM) begin
            armed            = 1'b1;
            expected_channel = w.channel;
            next_seq         = C_SEQ_EXPECT_INIT;
            cur_command      = '0;
            declared_len     = '0;
            received_count   = '0;
            if (byte_pos != 0) begin
                skip_report = 1'b1;
            end
            return;
        end
        if (!armed) begin
            skip_report = 1'b1;
        end
        if (skip_report) begin
        end else if (pos < 4) begin
            if (b != expected_channel[(24 - 8 * pos) +: 8]) begin
                skip_report = 1'b1;
            end
        end else if (pos == 4) begin
            if (b[7]) begin
                if (next_seq != C_SEQ_EXPECT_INIT && cur_command != C_CMD_KEEPALIVE) begin
                    fault = 1'b1;
                end else begin
                    cur_command    = b[6:0];
                    next_seq       = '0;
                    received_count = '0;
                    declared_len   = '0;
                end
            end else if (b == next_seq && next_seq < C_MAX_SEQUENCE) begin
                next_seq = next_seq + 8'd1;
            end else begin
                fault = 1'b1;
            end
        end else if (pos < 7 && next_seq == 8'd0) begin
            if (pos == 5) begin
                declared_len[15:8] = b;
            end else begin
                declared_len[7:0] = b;
            end
        end else if (pos < REPORT_BYTES) begin
            if (received_count != C_COUNT_MAX) begin
                received_count = received_count + 16'd1;
            end
            done = w.report_end && received_count >= declared_len;
            r.command        = cur_command;
            r.message_length = declared_len;
            r.payload_byte   = b;
            r.message_done   = done;
            emit = 1'b1;
        end else if (w.report_end && received_count >= declared_len) begin
            done = 1'b1;
            r.command        = cur_command;
            r.message_length = declared_len;
            r.message_done   = 1'b1;
            emit = 1'b1;
        end
        if (fault) begin
            cur_command    = C_CMD_ERROR;
            declared_len   = 16'd1;
            received_count = 16'd1;
            armed          = 1'b0;
            skip_report    = 1'b1;
            r.command        = C_CMD_ERROR;
            r.message_length = 16'd1;
            r.payload_byte   = C_ERR_INVALID_SEQ;
            r.message_done   = 1'b1;
            r.seq_fault      = 1'b1;
            emit = 1'b1;
        end else if (done && cur_command != C_CMD_KEEPALIVE) begin
            armed = 1'b0;
        end
        if (w.report_end) begin
            byte_pos    = '0;
            skip_report = 1'b0;
        end else if (pos < REPORT_BYTES) begin
            byte_pos = 7'(pos + 1);
        end
        if (emit) begin
            expected_words.push_back(r);
        end
    endtask

    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        reassemble(w);
        items_sent++;
    endtask

    task automatic send_arm(input logic [31:0] ch);
        t_in_word w;
        w.kind       = C_KIND_ARM;
        w.channel    = ch;
        w.data_byte  = 8'($urandom_range(255));
        w.report_end = 1'($urandom_range(1));
        send_word(w);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_word w;
        w.kind       = C_KIND_BYTE;
        w.channel    = $urandom;
        w.data_byte  = b;
        w.report_end = last;
        send_word(w);
    endtask

    // Header byte 4 with bit 7 set makes an initialisation packet, whose
    // length bytes follow; otherwise it is a continuation sequence number.
    task automatic send_report(input logic [31:0] ch, input logic [7:0] b4,
                               input logic [15:0] len, input int n_pay);
        int         total;
        logic [7:0] b;
        total = (b4[7] ? 7 : 5) + n_pay;
        for (int k = 0; k < total; k++) begin
            if (k < 4) begin
                b = ch[(24 - 8 * k) +: 8];
            end else if (k == 4) begin
                b = b4;
            end else if (b4[7] && k == 5) begin
                b = len[15:8];
            end else if (b4[7] && k == 6) begin
                b = len[7:0];
            end else begin
                b = 8'($urandom_range(255));
            end
            send_byte(b, k == total - 1);
        end
    endtask

    task automatic send_message(input logic [31:0] ch, input logic [6:0] cmd,
                                input int len, input int mode);
        int left;
        int chunk;
        int pay;
        int seq;
        int idx;
        int bad_idx;
        left  = len;
        chunk = $urandom_range(57);
        chunk = (chunk > left) ? left : chunk;
        send_report(ch, {1'b1, cmd}, 16'(len), chunk);
        left    = left - chunk;
        seq     = 0;
        idx     = 0;
        bad_idx = (mode != 0) ? $urandom_range(2) : -1;
        while (left > 0 || idx <= bad_idx) begin
            if ($urandom_range(15) == 0) begin
                send_report(ch ^ (32'd1 << $urandom_range(31)), {1'b0, seq[6:0]}, 16'd0, 2);
            end
            chunk = $urandom_range(1, 59);
            chunk = (chunk > left) ? left : chunk;
            pay   = ($urandom_range(19) == 0) ? $urandom_range(60, 64) : chunk;
            if (idx == bad_idx) begin
                if (mode == 1) begin
                    send_report(ch, {1'b0, 7'(seq + $urandom_range(1, 3))}, 16'd0, chunk);
                end else begin
                    send_report(ch, {1'b1, 7'($urandom)}, 16'($urandom), chunk);
                end
                break;
            end
            send_report(ch, {1'b0, seq[6:0]}, 16'd0, pay);
            left = left - ((pay > 59) ? 59 : pay);
            seq++;
            idx++;
        end
    endtask

    task automatic test_header_and_filter();
        send_report(32'h0000_0000, 8'h81, 16'd1, 1);
        send_arm(32'hFFFF_FFFF);
        send_report(32'hFFFF_FFFE, 8'h90, 16'd2, 2);
        send_report(32'hFFFF_FFFF, 8'h90, 16'd2, 2);
        send_report(32'hFFFF_FFFF, 8'h90, 16'd1, 1);
    endtask

    task automatic test_length_extremes();
        send_arm(32'h0000_0000);
        send_report(32'h0000_0000, 8'hFF, 16'hFFFF, 3);
        send_arm(32'h0000_0000);
        send_report(32'h0000_0000, 8'h80, 16'h0000, 0);
        send_report(32'h0000_0000, 8'h00, 16'h0000, 1);
        send_arm(32'h1234_5678);
        send_report(32'h1234_5678, 8'h83, 16'd1, 4);
    endtask

    task automatic test_sequence_faults();
        send_arm(32'hA5C3_0F11);
        send_report(32'hA5C3_0F11, 8'h90, 16'd100, 10);
        send_report(32'hA5C3_0F11, 8'h01, 16'd0, 3);
        send_arm(32'hA5C3_0F11);
        send_report(32'hA5C3_0F11, 8'h90, 16'd100, 5);
        send_report(32'hA5C3_0F11, 8'h91, 16'd5, 1);
        send_arm(32'hA5C3_0F11);
        send_report(32'hA5C3_0F11, 8'h00, 16'd0, 1);
        send_arm(32'hA5C3_0F11);
        send_report(32'hA5C3_0F11, {1'b1, C_CMD_KEEPALIVE}, 16'd200, 3);
        send_report(32'hA5C3_0F11, 8'h90, 16'd2, 2);
        send_arm(32'hA5C3_0F11);
        send_report(32'hA5C3_0F11, {1'b1, C_CMD_KEEPALIVE}, 16'd1, 1);
        send_report(32'hA5C3_0F11, 8'h90, 16'd1, 1);
    endtask

    task automatic test_report_shapes();
        logic [31:0] ch;
        ch = 32'h5A3C_9617;
        send_arm(ch);
        send_byte(ch[31:24], 1'b0);
        send_byte(ch[23:16], 1'b0);
        send_byte(ch[15:8], 1'b1);
        for (int k = 0; k < 4; k++) begin
            send_byte(ch[(24 - 8 * k) +: 8], 1'b0);
        end
        send_byte(8'h90, 1'b0);
        send_byte(8'h00, 1'b1);
        send_report(ch, 8'h00, 16'd0, 2);
        send_arm(ch);
        send_report(ch, 8'h90, 16'd10, 62);
        send_arm(ch);
        send_byte(ch[31:24], 1'b0);
        send_byte(ch[23:16], 1'b0);
        send_arm(ch);
        send_byte(ch[15:8], 1'b0);
        send_byte(ch[7:0], 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hC7, 1'b1);
        send_report(ch, 8'h90, 16'd1, 1);
    endtask

    task automatic test_sequence_limit();
        logic [31:0] ch;
        ch = $urandom;
        send_arm(ch);
        send_report(ch, 8'h90, 16'hFFFF, 1);
        for (int s = 0; s < 128; s++) begin
            send_report(ch, 8'(s), 16'd0, 0);
        end
        send_report(ch, 8'h00, 16'd0, 1);
    endtask

    task automatic test_backpressure();
        logic [31:0] ch;
        ch = $urandom;
        send_arm(ch);
        hold_requests++;
        send_message(ch, 7'h10, 50, 0);
    endtask

    task automatic random_exchange();
        logic [31:0] ch;
        int          sel;
        int          len;
        int          mode;
        sel = $urandom_range(7);
        ch  = (sel == 0) ? 32'h0000_0000 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
        sel = $urandom_range(99);
        if (sel < 6) begin
            send_report($urandom, 8'($urandom_range(255)), 16'($urandom),
                        $urandom_range(8));
        end else if (sel < 10) begin
            send_arm(ch);
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                send_byte((k < 4) ? ch[(24 - 8 * k) +: 8] : 8'($urandom), 1'b0);
            end
            send_arm(ch);
            send_report(ch, {1'b1, 7'($urandom)}, 16'($urandom_range(10)),
                        $urandom_range(8));
        end else begin
            send_arm(ch);
            if ($urandom_range(3) == 0) begin
                send_message(ch, C_CMD_KEEPALIVE, $urandom_range(3), 0);
            end
            len  = ($urandom_range(9) == 0) ? $urandom_range(150, 400) : $urandom_range(80);
            mode = ($urandom_range(9) < 8) ? 0 : $urandom_range(1, 2);
            send_message(ch, 7'($urandom), len, mode);
        end
    endtask

    task automatic test_random_traffic(input int n);
        int start;
        start = items_sent;
        while (items_sent - start < n) begin
            random_exchange();
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left  = hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected word: cmd=%h len=%h byte=%h done=%b fault=%b",
                             o_out_word.command, o_out_word.message_length,
                             o_out_word.payload_byte, o_out_word.message_done,
                             o_out_word.seq_fault);
                end
            end else begin
                want = expected_words.pop_front();
                if (o_out_word.command !== want.command
                        || o_out_word.message_length !== want.message_length
                        || o_out_word.payload_byte !== want.payload_byte
                        || o_out_word.message_done !== want.message_done
                        || o_out_word.seq_fault !== want.seq_fault) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected cmd=%h len=%h byte=%h done=%b fault=%b",
                                 want.command, want.message_length, want.payload_byte,
                                 want.message_done, want.seq_fault);
                        $display("          actual   cmd=%h len=%h byte=%h done=%b fault=%b",
                                 o_out_word.command, o_out_word.message_length,
                                 o_out_word.payload_byte, o_out_word.message_done,
                                 o_out_word.seq_fault);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_ctaphid_response_reassembler: FAIL");
            $finish;
        end
    end

    initial begin
        armed            = 1'b0;
        expected_channel = '0;
        byte_pos         = '0;
        next_seq         = C_SEQ_EXPECT_INIT;
        cur_command      = '0;
        declared_len     = '0;
        received_count   = '0;
        skip_report      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 68;
        test_header_and_filter();
        test_length_extremes();
        test_sequence_faults();
        test_report_shapes();
        test_random_traffic(RANDOM_ITEMS / 3);

        send_idle_pct = 68;
        recv_idle_pct = 11;
        test_backpressure();
        test_random_traffic(RANDOM_ITEMS / 3);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_sequence_limit();
        test_random_traffic(RANDOM_ITEMS / 3);

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("tb_ctaphid_response_reassembler: PASS");
        end else begin
            $display("tb_ctaphid_response_reassembler: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
src/ctrh_pkg.sv
src/ctrh_core.sv
src/ctrh_out_buf.sv
src/ctaphid_response_reassembler.sv
src/ctrh_checker.sv
tb/tb_ctaphid_response_reassembler.sv
